// File: rtl/bc_texture_block_decoder_top_assert.svh
// Assertion macros for the texture block decoder
`ifndef BC_TEXTURE_BLOCK_DECODER_TOP_ASSERT_SVH
`define BC_TEXTURE_BLOCK_DECODER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define BCD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset
`define BCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/bctd_pkg.sv
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types, constants and helpers of the texture block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bctd_pkg;

  typedef enum logic [1:0] {
    FMT_BC1 = 2'd0,
    FMT_BC2 = 2'd1,
    FMT_BC3 = 2'd2,
    FMT_BC5 = 2'd3
  } fmt_t;

  localparam logic [0:0] REG_FORMAT = 1'b0;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned TEXELS = 16;
  localparam int unsigned ROOT_STAGES = 8;  // square root stages, one result bit each

  // A block as held in the queue: colour palette, channel palettes, indices.
  typedef struct packed {
    fmt_t            fmt;
    logic [3:0][7:0] pb;
    logic [3:0][7:0] pg;
    logic [3:0][7:0] pr;
    logic [3:0]      pa_opaque;
    logic [31:0]     cidx;
    logic [7:0][7:0] c0p;
    logic [7:0][7:0] c1p;
    logic [47:0]     a0idx;
    logic [47:0]     a1idx;
    logic [63:0]     nib;
  } blk_t;

  // 5-bit and 6-bit endpoint expansion, v*255/max truncated, by reciprocal
  // multiplication that is exact over the whole field range
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [25:0] t;
    t = 26'(v) * 26'd2156535;  // 255 * 8457, 8457 / 2^18 ~ 1/31
    return 8'(t >> 18);
  endfunction

  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [27:0] t;
    t = 28'(v) * 28'd4244475;  // 255 * 16645, 16645 / 2^20 ~ 1/63
    return 8'(t >> 20);
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [20:0] t;
    t = 21'(v) * 21'd683;
    return 8'(t >> 11);
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [23:0] t;
    t = 24'(v) * 24'd2341;
    return 8'(t >> 14);
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [23:0] t;
    t = 24'(v) * 24'd3277;
    return 8'(t >> 14);
  endfunction

endpackage

// File: rtl/bctd_front.sv
// ----------------------------------------------------------------------------
// bctd_front
// Accepts blocks and builds the colour and channel palettes of each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bctd_front (
  input  logic              clk,
  input  logic              rst,
  input  bctd_pkg::fmt_t    fmt,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       block_low,
  input  logic [63:0]       block_high,
  output logic              blk_valid,
  input  logic              blk_ready,
  output bctd_pkg::blk_t    blk
);

  bctd_pkg::blk_t blk_next;
  logic [63:0] cw;
  logic [15:0] c0, c1;
  logic        four;
  logic [7:0]  e0r, e0g, e0b, e1r, e1g, e1b;

  assign in_ready = !blk_valid || blk_ready;

  function automatic logic [7:0][7:0] chpal(input logic [15:0] w);
    logic [7:0] a0, a1;
    logic [7:0][7:0] p;
    a0 = w[7:0];
    a1 = w[15:8];
    p[0] = a0;
    p[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        p[k+1] = bctd_pkg::div7(11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1));
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        p[k+1] = bctd_pkg::div5(11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1));
      end
      p[6] = 8'd0;
      p[7] = 8'd255;
    end
    return p;
  endfunction

  always_comb begin
    cw   = (fmt == bctd_pkg::FMT_BC1) ? block_low : block_high;
    c0   = cw[15:0];
    c1   = cw[31:16];
    four = (fmt != bctd_pkg::FMT_BC1) || (c0 > c1);
    e0r  = bctd_pkg::exp5(c0[15:11]);
    e0g  = bctd_pkg::exp6(c0[10:5]);
    e0b  = bctd_pkg::exp5(c0[4:0]);
    e1r  = bctd_pkg::exp5(c1[15:11]);
    e1g  = bctd_pkg::exp6(c1[10:5]);
    e1b  = bctd_pkg::exp5(c1[4:0]);
    blk_next.fmt = fmt;
    blk_next.pr[0] = e0r; blk_next.pg[0] = e0g; blk_next.pb[0] = e0b;
    blk_next.pr[1] = e1r; blk_next.pg[1] = e1g; blk_next.pb[1] = e1b;
    if (four) begin
      blk_next.pr[2] = bctd_pkg::div3({e0r, 1'b0} + 10'(e1r));
      blk_next.pg[2] = bctd_pkg::div3({e0g, 1'b0} + 10'(e1g));
      blk_next.pb[2] = bctd_pkg::div3({e0b, 1'b0} + 10'(e1b));
      blk_next.pr[3] = bctd_pkg::div3(10'(e0r) + {e1r, 1'b0});
      blk_next.pg[3] = bctd_pkg::div3(10'(e0g) + {e1g, 1'b0});
      blk_next.pb[3] = bctd_pkg::div3(10'(e0b) + {e1b, 1'b0});
      blk_next.pa_opaque = 4'b1111;
    end else begin
      blk_next.pr[2] = 8'((9'(e0r) + 9'(e1r)) >> 1);
      blk_next.pg[2] = 8'((9'(e0g) + 9'(e1g)) >> 1);
      blk_next.pb[2] = 8'((9'(e0b) + 9'(e1b)) >> 1);
      blk_next.pr[3] = 8'd0;
      blk_next.pg[3] = 8'd0;
      blk_next.pb[3] = 8'd0;
      blk_next.pa_opaque = 4'b0111;
    end
    blk_next.cidx  = cw[63:32];
    blk_next.c0p   = chpal(block_low[15:0]);
    blk_next.c1p   = chpal(block_high[15:0]);
    blk_next.a0idx = block_low[63:16];
    blk_next.a1idx = block_high[63:16];
    blk_next.nib   = block_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (in_ready) begin
      blk_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      blk <= blk_next;
    end
  end

endmodule

// File: rtl/bctd_queue.sv
// ----------------------------------------------------------------------------
// bctd_queue
// Two-entry block queue between the front and back halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bctd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  bctd_pkg::blk_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output bctd_pkg::blk_t rd_data
);

  bctd_pkg::blk_t mem [bctd_pkg::QDEPTH];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

// File: rtl/bctd_back.sv
// ----------------------------------------------------------------------------
// bctd_back
// Walks the sixteen texels of a block; pipelined square root for BC5 blue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bctd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           blk_valid,
  output logic           blk_ready,
  input  bctd_pkg::blk_t blk,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     blue,
  output logic [7:0]     green,
  output logic [7:0]     red,
  output logic [7:0]     alpha,
  output logic [3:0]     texel_index,
  output logic           last_texel
);

  typedef struct packed {
    logic       v;
    logic [7:0] b, g, r, a;
    logic [3:0] idx;
    logic       bc5;
    logic [16:0] rem;
    logic [8:0]  root;
  } stg_t;

  logic [3:0]  cnt;
  logic        adv;
  stg_t        st [bctd_pkg::ROOT_STAGES+1];
  stg_t        st_next [bctd_pkg::ROOT_STAGES+1];
  stg_t        s0;
  logic [1:0]  ci;
  logic [2:0]  i0, i1;
  logic [7:0]  ch0, ch1;
  logic signed [9:0] dr, dg;
  logic signed [19:0] d;
  logic [19:0] trial;

  // whole pipe moves when the output is free
  assign adv       = !out_valid || out_ready;
  assign blk_ready = adv && (cnt == 4'd15);

  always_comb begin
    ci  = blk.cidx[2*cnt +: 2];
    i0  = blk.a0idx[3*cnt +: 3];
    i1  = blk.a1idx[3*cnt +: 3];
    ch0 = blk.c0p[i0];
    ch1 = blk.c1p[i1];
    dr  = $signed({1'b0, ch0, 1'b0}) - 10'sd255;
    dg  = $signed({1'b0, ch1, 1'b0}) - 10'sd255;
    d   = 20'sd65025 - dr * dr - dg * dg;
    s0      = '0;
    s0.v    = blk_valid;
    s0.idx  = cnt;
    s0.b    = blk.pb[ci];
    s0.g    = blk.pg[ci];
    s0.r    = blk.pr[ci];
    s0.a    = blk.pa_opaque[ci] ? 8'd255 : 8'd0;
    unique case (blk.fmt)
      bctd_pkg::FMT_BC1: ;
      bctd_pkg::FMT_BC2: s0.a = {blk.nib[4*cnt +: 4], blk.nib[4*cnt +: 4]};
      bctd_pkg::FMT_BC3: s0.a = ch0;
      bctd_pkg::FMT_BC5: begin
        s0.bc5 = 1'b1;
        s0.r   = ch0;
        s0.g   = ch1;
        s0.a   = 8'd255;
        s0.rem = d > 0 ? 17'(d) : 17'd0;
      end
      default: ;
    endcase
  end

  // restoring square root, stage k settles result bit ROOT_STAGES-1-k
  always_comb begin
    trial = '0;
    st_next[0] = s0;
    for (int k = 0; k < bctd_pkg::ROOT_STAGES; k++) begin
      trial = 20'({st[k].root, 2'b01}) << (2 * (bctd_pkg::ROOT_STAGES - 1 - k));
      st_next[k+1] = st[k];
      if (st[k].bc5) begin
        if (trial <= 20'(st[k].rem)) begin
          st_next[k+1].rem  = 17'(20'(st[k].rem) - trial);
          st_next[k+1].root = {st[k].root[7:0], 1'b1};
        end else begin
          st_next[k+1].root = {st[k].root[7:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (adv && blk_valid) begin
      cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= bctd_pkg::ROOT_STAGES; k++) st[k].v <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k <= bctd_pkg::ROOT_STAGES; k++) st[k] <= st_next[k];
    end
  end

  assign out_valid   = st[bctd_pkg::ROOT_STAGES].v;
  assign blue        = st[bctd_pkg::ROOT_STAGES].bc5 ?
                       8'((10'(st[bctd_pkg::ROOT_STAGES].root) + 10'd256) >> 1) :
                       st[bctd_pkg::ROOT_STAGES].b;
  assign green       = st[bctd_pkg::ROOT_STAGES].g;
  assign red         = st[bctd_pkg::ROOT_STAGES].r;
  assign alpha       = st[bctd_pkg::ROOT_STAGES].a;
  assign texel_index = st[bctd_pkg::ROOT_STAGES].idx;
  assign last_texel  = (st[bctd_pkg::ROOT_STAGES].idx == 4'd15);

endmodule

// File: rtl/bc_texture_block_decoder_top.sv
// Texture block decoder: takes one 4x4 BC1/BC2/BC3/BC5 block per word and
// gives its sixteen texels as BGRA words, row-major, the sixteenth flagged.
// One texel leaves per cycle while out_ready holds and a block is queued;
// the texel walker in the back half sets that rate. A block passes a palette
// stage and the queue, each texel a texel stage and an eight-stage square root.
// ----------------------------------------------------------------------------
// bc_texture_block_decoder_top
// Top level: config register, front palette builder, queue, texel walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bc_texture_block_decoder_top_assert.svh"

module bc_texture_block_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid,
  output logic        ready,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic [7:0]  alpha,
  output logic [3:0]  texel_index,
  output logic        last_texel
);

  bctd_pkg::fmt_t fmt;
  bctd_pkg::blk_t f_blk, q_blk;
  logic f_valid, f_ready, q_valid, q_ready;

  // only register 0 (byte address 0) exists
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {30'd0, fmt} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= bctd_pkg::FMT_BC1;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      fmt <= bctd_pkg::fmt_t'(pwdata[1:0]);
    end
  end

  bctd_front u_front (
    .clk, .rst, .fmt, .in_valid(valid), .in_ready(ready),
    .block_low, .block_high,
    .blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
  );

  bctd_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_blk)
  );

  bctd_back u_back (
    .clk, .rst, .blk_valid(q_valid), .blk_ready(q_ready), .blk(q_blk),
    .out_valid, .out_ready, .blue, .green, .red, .alpha, .texel_index, .last_texel
  );

  // a block leaves the queue only with its sixteenth texel
  `BCD_ASSERT_IMPL(a_pop_last, clk, rst, q_valid && q_ready, u_back.cnt == 4'd15)
  // the texel after a last texel starts a new block
  `BCD_ASSERT_NEXT(a_wrap, clk, rst, out_valid && out_ready && last_texel, !out_valid || texel_index == 4'd0)

endmodule
